@@ rtl/vision_target_hold_and_smooth_defines.svh @@
// Assertion macros for the vision target hold and smooth block
`ifndef VISION_TARGET_HOLD_AND_SMOOTH_DEFINES_SVH
`define VISION_TARGET_HOLD_AND_SMOOTH_DEFINES_SVH

// same-cycle implication, checked outside reset
`define VTHS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define VTHS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/vths_pkg.sv @@
// Shared types and constants for the vision target hold and smooth block
`timescale 1ns / 1ps

package vths_pkg;

  localparam int unsigned ANGLE_W = 32;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned ALPHA_W = 17;
  localparam int unsigned CFG_W   = 32;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_ALPHA   = 1'b1;

  typedef struct packed {
    logic [TICK_W-1:0]         sys_tick;
    logic                      link_online;
    logic [TICK_W-1:0]         frame_seq;
    logic                      frame_target_valid;
    logic signed [ANGLE_W-1:0] frame_pitch;
    logic signed [ANGLE_W-1:0] frame_yaw;
  } vths_in_t;

  typedef struct packed {
    logic                      target_lock;
    logic signed [ANGLE_W-1:0] smoothed_pitch;
    logic signed [ANGLE_W-1:0] smoothed_yaw;
  } vths_out_t;

  typedef struct packed {
    logic                      avail;
    logic signed [ANGLE_W-1:0] held_pitch;
    logic signed [ANGLE_W-1:0] held_yaw;
  } vths_hold_t;

endpackage

@@ rtl/vths_hold.sv @@
// Frame latch and target age check
`timescale 1ns / 1ps

module vths_hold import vths_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  vths_in_t          word,
  input  logic [TICK_W-1:0] timeout_ticks,
  output vths_hold_t        status
);

  logic [TICK_W-1:0]         seen_seq;
  logic [TICK_W-1:0]         valid_stamp;
  logic signed [ANGLE_W-1:0] held_pitch;
  logic signed [ANGLE_W-1:0] held_yaw;
  logic                      have_target;

  logic                      latch;
  logic [TICK_W-1:0]         stamp_next;
  logic signed [ANGLE_W-1:0] held_pitch_next;
  logic signed [ANGLE_W-1:0] held_yaw_next;
  logic                      have_target_next;
  logic [TICK_W-1:0]         age;

  assign latch            = (word.frame_seq != seen_seq) && word.frame_target_valid;
  assign stamp_next       = latch ? word.sys_tick : valid_stamp;
  assign held_pitch_next  = latch ? word.frame_pitch : held_pitch;
  assign held_yaw_next    = latch ? word.frame_yaw : held_yaw;
  assign have_target_next = have_target || latch;
  assign age              = word.sys_tick - stamp_next;

  always_comb begin
    status.avail      = have_target_next && word.link_online && (age <= timeout_ticks);
    status.held_pitch = held_pitch_next;
    status.held_yaw   = held_yaw_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_seq    <= '0;
      valid_stamp <= '0;
      held_pitch  <= '0;
      held_yaw    <= '0;
      have_target <= 1'b0;
    end else if (fire) begin
      seen_seq    <= word.frame_seq;
      valid_stamp <= stamp_next;
      held_pitch  <= held_pitch_next;
      held_yaw    <= held_yaw_next;
      have_target <= have_target_next;
    end
  end

endmodule

@@ rtl/vths_axis.sv @@
// One axis of the first-order low pass filter
`timescale 1ns / 1ps

module vths_axis import vths_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      fire,
  input  logic                      avail,
  input  logic                      tracking,
  input  logic signed [ANGLE_W-1:0] held,
  input  logic [ALPHA_W-1:0]        alpha,
  output logic signed [ANGLE_W-1:0] filt_next
);

  localparam int unsigned DIFF_W = ANGLE_W + 1;
  localparam int unsigned PROD_W = DIFF_W + ALPHA_W + 1;

  logic signed [ANGLE_W-1:0] filt;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  step;
  logic signed [PROD_W-1:0]  sum;

  assign diff = DIFF_W'(held) - DIFF_W'(filt);
  assign prod = PROD_W'($signed({1'b0, alpha})) * PROD_W'(diff);
  assign step = prod >>> 16;
  assign sum  = PROD_W'(filt) + step;

  always_comb begin
    priority if (!avail) begin
      filt_next = filt;
    end else if (!tracking) begin
      filt_next = held;
    end else begin
      filt_next = sum[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filt <= '0;
    end else if (fire) begin
      filt <= filt_next;
    end
  end

endmodule

@@ rtl/vision_target_hold_and_smooth.sv @@
// Top level: hold the latest vision target and smooth its angles
//
//  port group   dir   handshake              word
//  in_*         in    in_valid / in_ready    vths_in_t
//  out_*        out   out_valid / out_ready  vths_out_t
//  cfg_*        in    cfg_we                 index, 32-bit data
//
// One word is taken per cycle while in_ready is high; its result passes through the input register
// and then the result register around the filter multiply.
// Synchronous reset clears the held target, filter state and both stages;
// alpha returns to pass-through and the timeout to zero.
// A stalled result holds in the result register while one more word waits
// in the input register; only then does in_ready fall.
`timescale 1ns / 1ps
`include "vision_target_hold_and_smooth_defines.svh"

module vision_target_hold_and_smooth import vths_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  vths_in_t         in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output vths_out_t        out_word,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [TICK_W-1:0]  timeout_ticks;
  logic [ALPHA_W-1:0] smoothing_alpha;
  logic [ALPHA_W-1:0] alpha_sat;

  logic      in_full;
  vths_in_t  in_q;
  logic      fire;
  logic      tracking;
  vths_hold_t status;
  logic signed [ANGLE_W-1:0] pitch_next;
  logic signed [ANGLE_W-1:0] yaw_next;

  assign fire      = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || fire;
  assign alpha_sat = (smoothing_alpha > ALPHA_ONE) ? ALPHA_ONE : smoothing_alpha;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks   <= '0;
      smoothing_alpha <= ALPHA_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIMEOUT: timeout_ticks   <= cfg_data[TICK_W-1:0];
        CFG_ALPHA:   smoothing_alpha <= cfg_data[ALPHA_W-1:0];
        default:     ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_word;
    end
  end

  vths_hold u_hold (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .word          (in_q),
    .timeout_ticks (timeout_ticks),
    .status        (status)
  );

  vths_axis u_pitch (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .avail     (status.avail),
    .tracking  (tracking),
    .held      (status.held_pitch),
    .alpha     (alpha_sat),
    .filt_next (pitch_next)
  );

  vths_axis u_yaw (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .avail     (status.avail),
    .tracking  (tracking),
    .held      (status.held_yaw),
    .alpha     (alpha_sat),
    .filt_next (yaw_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tracking <= 1'b0;
    end else if (fire) begin
      tracking <= status.avail;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word.target_lock    <= status.avail;
      out_word.smoothed_pitch <= pitch_next;
      out_word.smoothed_yaw   <= yaw_next;
    end
  end

  `VTHS_ASSERT_NOW(a_stall_only_full, clk, rst, !in_ready, in_full && out_valid && !out_ready, "input stalled without a full pipe")
  `VTHS_ASSERT_NEXT(a_fire_loads_out, clk, rst, fire, out_valid, "advanced word did not reach the result register")
  `VTHS_ASSERT_NEXT(a_track_follows, clk, rst, fire, tracking == out_word.target_lock, "tracking out of step with delivered availability")

endmodule

@@ sim/tb_vision_target_hold_and_smooth.sv @@
// Testbench for the vision target hold and smooth block: directed table, then random words
`timescale 1ns / 1ps
module tb_vision_target_hold_and_smooth;
  import vths_pkg::*;

  localparam int CLK_LIMIT         = 200000;
  localparam int HOLD_CYCLES       = 160;
  localparam int WORDS_PER_SETTING = 242;
  localparam int PRINT_CAP         = 60;

  typedef struct packed {
    bit          is_cfg;
    logic [31:0] tmo;
    logic [31:0] alpha_data;
    vths_in_t    w;
    bit          known;
    vths_out_t   res;
  } plan_row_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  vths_in_t         in_word   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  vths_out_t        out_word;
  logic             cfg_we    = 1'b0;
  logic             cfg_index = CFG_TIMEOUT;
  logic [CFG_W-1:0] cfg_data  = '0;

  int send_idle = 0;
  int recv_idle = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles    = 0;
  int errors    = 0;

  vths_out_t pending_q[$];
  plan_row_t plan[$];

  logic [TICK_W-1:0]         tmo_ticks = '0;
  logic [ALPHA_W-1:0]        alpha_q16 = ALPHA_ONE;
  logic [TICK_W-1:0]         seen_seq  = '0;
  logic [TICK_W-1:0]         stamp     = '0;
  logic signed [ANGLE_W-1:0] held_p    = '0;
  logic signed [ANGLE_W-1:0] held_y    = '0;
  logic signed [ANGLE_W-1:0] filt_p    = '0;
  logic signed [ANGLE_W-1:0] filt_y    = '0;
  logic                      have_tgt  = 1'b0;
  logic                      tracking  = 1'b0;

  vision_target_hold_and_smooth u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CLK_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      out_ready <= 1'b0;
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin : watch
    vths_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= PRINT_CAP)
          $display("%0t: result word with none expected, got %h", $time, out_word);
      end else begin
        want = pending_q.pop_front();
        if (out_word.target_lock !== want.target_lock) begin
          errors++;
          if (errors <= PRINT_CAP)
            $display("%0t: target_lock expected %0d got %0d", $time,
                     want.target_lock, out_word.target_lock);
        end
        if (out_word.smoothed_pitch !== want.smoothed_pitch) begin
          errors++;
          if (errors <= PRINT_CAP)
            $display("%0t: smoothed_pitch expected %h got %h", $time,
                     want.smoothed_pitch, out_word.smoothed_pitch);
        end
        if (out_word.smoothed_yaw !== want.smoothed_yaw) begin
          errors++;
          if (errors <= PRINT_CAP)
            $display("%0t: smoothed_yaw expected %h got %h", $time,
                     want.smoothed_yaw, out_word.smoothed_yaw);
        end
      end
    end
  end

  // floor(alpha * (goal - cur) / 2^16) added to cur
  function automatic logic signed [ANGLE_W-1:0] ease(input logic signed [ANGLE_W-1:0] cur,
                                                     input logic signed [ANGLE_W-1:0] goal,
                                                     input logic [ALPHA_W-1:0] a);
    longint gap;
    longint stp;
    gap = longint'(goal) - longint'(cur);
    stp = (longint'(a) * gap) >>> 16;
    return cur + stp[31:0];
  endfunction

  function automatic vths_out_t track_and_smooth(input vths_in_t w);
    vths_out_t          r;
    logic [TICK_W-1:0]  age;
    logic [ALPHA_W-1:0] a;
    logic               avail;
    if (w.frame_seq != seen_seq) begin
      seen_seq = w.frame_seq;
      if (w.frame_target_valid) begin
        held_p   = w.frame_pitch;
        held_y   = w.frame_yaw;
        stamp    = w.sys_tick;
        have_tgt = 1'b1;
      end
    end
    age   = w.sys_tick - stamp;
    avail = have_tgt && w.link_online && (age <= tmo_ticks);
    a     = (alpha_q16 > ALPHA_ONE) ? ALPHA_ONE : alpha_q16;
    if (!avail) begin
      tracking = 1'b0;
    end else if (!tracking) begin
      filt_p   = held_p;
      filt_y   = held_y;
      tracking = 1'b1;
    end else begin
      filt_p = ease(filt_p, held_p, a);
      filt_y = ease(filt_y, held_y, a);
    end
    r.target_lock    = avail;
    r.smoothed_pitch = filt_p;
    r.smoothed_yaw   = filt_y;
    return r;
  endfunction

  function automatic plan_row_t word_row(input logic [31:0] now, input logic on,
                                        input logic [31:0] seq, input logic fv,
                                        input logic [31:0] p, input logic [31:0] y);
    plan_row_t r;
    r = '0;
    r.w.sys_tick           = now;
    r.w.link_online        = on;
    r.w.frame_seq          = seq;
    r.w.frame_target_valid = fv;
    r.w.frame_pitch        = p;
    r.w.frame_yaw          = y;
    return r;
  endfunction

  function automatic plan_row_t known_row(input logic [31:0] now, input logic on,
                                         input logic [31:0] seq, input logic fv,
                                         input logic [31:0] p, input logic [31:0] y,
                                         input logic av, input logic [31:0] sp,
                                         input logic [31:0] sy);
    plan_row_t r;
    r = word_row(now, on, seq, fv, p, y);
    r.known              = 1'b1;
    r.res.target_lock    = av;
    r.res.smoothed_pitch = sp;
    r.res.smoothed_yaw   = sy;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [31:0] tmo, input logic [31:0] alpha_data);
    plan_row_t r;
    r = '0;
    r.is_cfg     = 1'b1;
    r.tmo        = tmo;
    r.alpha_data = alpha_data;
    return r;
  endfunction

  function automatic logic [31:0] pick_angle();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) begin
      case ($urandom_range(3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end else if (r < 60) begin
      return $urandom_range(32'h001F_FFFF) - 32'h0010_0000;
    end
    return $urandom;
  endfunction

  task automatic set_regs(input logic [31:0] tmo, input logic [31:0] alpha_data);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TIMEOUT;
    cfg_data  <= tmo;
    @(posedge clk);
    cfg_index <= CFG_ALPHA;
    cfg_data  <= alpha_data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tmo_ticks = tmo;
    alpha_q16 = alpha_data[ALPHA_W-1:0];
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic send_word(input vths_in_t w, input bit known, input vths_out_t res);
    vths_out_t pred;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = track_and_smooth(w);
    pending_q.push_back(known ? res : pred);
  endtask

  initial begin : stimulus
    vths_in_t    w;
    logic [31:0] now_acc;
    logic [31:0] seq_acc;
    int unsigned r;

    // repeated sequence after reset, frame without target, extremes, hold, timeout, link down
    plan.push_back(known_row(32'd0, 1'b1, 32'd0, 1'b1, 32'h1234_0000, 32'hFFED_0000,
                             1'b0, 32'h0, 32'h0));
    plan.push_back(known_row(32'd1, 1'b1, 32'd1, 1'b0, 32'h0005_0000, 32'h0006_0000,
                             1'b0, 32'h0, 32'h0));
    plan.push_back(known_row(32'd2, 1'b1, 32'd2, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000,
                             1'b1, 32'h7FFF_FFFF, 32'h8000_0000));
    plan.push_back(known_row(32'd2, 1'b1, 32'd2, 1'b1, 32'h0, 32'h0,
                             1'b1, 32'h7FFF_FFFF, 32'h8000_0000));
    plan.push_back(known_row(32'd3, 1'b1, 32'd2, 1'b1, 32'h0, 32'h0,
                             1'b0, 32'h7FFF_FFFF, 32'h8000_0000));
    plan.push_back(known_row(32'd3, 1'b0, 32'd3, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF,
                             1'b0, 32'h7FFF_FFFF, 32'h8000_0000));
    plan.push_back(known_row(32'd3, 1'b1, 32'd3, 1'b0, 32'h0, 32'h0,
                             1'b1, 32'h8000_0000, 32'h7FFF_FFFF));
    // widest timeout, alpha zero holds the filter
    plan.push_back(cfg_row(32'hFFFF_FFFF, 32'h0));
    plan.push_back(known_row(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'h0001_0000,
                             32'hFFFF_0000, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF));
    plan.push_back(known_row(32'h7FFF_FFFE, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0,
                             1'b1, 32'h8000_0000, 32'h7FFF_FFFF));
    plan.push_back(known_row(32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'h0, 32'h0,
                             1'b1, 32'h8000_0000, 32'h7FFF_FFFF));
    // alpha above one saturates to pass-through
    plan.push_back(cfg_row(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    plan.push_back(known_row(32'h0, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'h0, 32'h0,
                             1'b1, 32'h0001_0000, 32'hFFFF_0000));
    plan.push_back(cfg_row(32'd10, 32'h0000_8000));
    plan.push_back(word_row(32'd100, 1'b1, 32'd5, 1'b1, 32'h0002_0000, 32'hFFFE_0000));
    plan.push_back(word_row(32'd110, 1'b1, 32'd5, 1'b1, 32'h0, 32'h0));
    plan.push_back(word_row(32'd111, 1'b1, 32'd5, 1'b1, 32'h0, 32'h0));
    plan.push_back(word_row(32'd111, 1'b1, 32'd6, 1'b1, 32'h1, 32'hFFFF_FFFF));
    plan.push_back(word_row(32'd112, 1'b1, 32'd7, 1'b1, 32'h0, 32'h0));
    plan.push_back(cfg_row(32'd10, 32'h1));
    plan.push_back(word_row(32'd113, 1'b1, 32'd8, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000));
    plan.push_back(word_row(32'd114, 1'b1, 32'd8, 1'b1, 32'h0, 32'h0));
    plan.push_back(word_row(32'd114, 1'b0, 32'd8, 1'b1, 32'h0, 32'h0));

    send_idle = 27;
    recv_idle = 68;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        set_regs(plan[i].tmo, plan[i].alpha_data);
      end else begin
        send_word(plan[i].w, plan[i].known, plan[i].res);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      send_idle = (ph < 2) ? 27 : (ph < 4) ? 68 : 0;
      recv_idle = (ph < 2) ? 68 : (ph < 4) ? 27 : 0;
      case (ph)
        0:       set_regs($urandom_range(30), $urandom_range(ALPHA_ONE));
        1:       set_regs(32'hFFFF_FFFF, 32'h0);
        2:       set_regs($urandom_range(30), ($urandom & 32'hFFFE_0000) | ALPHA_ONE);
        3:       set_regs(32'h0, $urandom_range(ALPHA_ONE));
        4:       set_regs($urandom_range(1000),
                          ($urandom & 32'hFFFE_0000) | $urandom_range(ALPHA_ONE + 1, 17'h1FFFF));
        default: set_regs($urandom, $urandom);
      endcase
      now_acc = $urandom;
      seq_acc = $urandom;
      for (int n = 0; n < WORDS_PER_SETTING; n++) begin
        r = $urandom_range(99);
        if (r < 70) now_acc += $urandom_range(2);
        else if (r < 95) now_acc += $urandom_range(1, 40);
        else now_acc = $urandom;
        r = $urandom_range(99);
        if (r < 50) seq_acc += 1;
        else if (r >= 95) seq_acc = $urandom;
        else if (r >= 80) seq_acc += $urandom_range(2, 9);
        w.sys_tick           = now_acc;
        w.link_online        = ($urandom_range(99) < 90);
        w.frame_seq          = seq_acc;
        w.frame_target_valid = ($urandom_range(99) < 80);
        w.frame_pitch        = pick_angle();
        w.frame_yaw          = pick_angle();
        // hold the result side off while words keep coming
        if (ph == 4 && n == 40) hold_reqs <= hold_reqs + 1;
        send_word(w, 1'b0, '0);
      end
    end

    settle();
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/vths_pkg.sv
rtl/vths_hold.sv
rtl/vths_axis.sv
rtl/vision_target_hold_and_smooth.sv
sim/tb_vision_target_hold_and_smooth.sv
